FILE: sv/huffman_table_encoder_macros.svh
// ----------------------------------------------------------------------------
// huffman table encoder assertion macros
// shared property forms, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TABLE_ENCODER_MACROS_SVH
`define HUFFMAN_TABLE_ENCODER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define HTE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("huffman table encoder: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define HTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("huffman table encoder: next-cycle check failed");

`endif

FILE: sv/hte_pkg.sv
// ----------------------------------------------------------------------------
// hte_pkg
// types and constants shared by the huffman table encoder files
// ----------------------------------------------------------------------------
package hte_pkg;

    // table geometry
    localparam int TABLE_DEPTH   = 256;
    localparam int ADDR_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int MAX_CODE_BITS = 16;
    localparam int WORD_BITS     = 16;
    localparam int LEN_CAP       = (MAX_CODE_BITS < WORD_BITS) ? MAX_CODE_BITS : WORD_BITS;
    localparam int LEN_W         = 5;
    localparam int ENTRY_W       = WORD_BITS + LEN_W;

    // bit packer geometry
    localparam int BYTE_BITS = 8;
    localparam int PEND_BITS = 7;
    localparam int CNT_W     = 3;
    localparam int ACC_W     = PEND_BITS + WORD_BITS;

    // command codes
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } cmd_t;

    // request from the lookup stage to the packer
    typedef struct packed {
        cmd_t                   cmd;
        logic [LEN_W-1:0]       clen;
        logic [WORD_BITS-1:0]   code;
    } pack_req_t;

    // bytes produced by one request
    typedef struct packed {
        logic [1:0]             count;
        logic [BYTE_BITS-1:0]   byte0;
        logic [BYTE_BITS-1:0]   byte1;
    } pack_res_t;

endpackage

FILE: sv/hte_if.sv
// ----------------------------------------------------------------------------
// hte_cmd_if / hte_byte_if
// valid/ready channels for commands in and packed bytes out
// ----------------------------------------------------------------------------
interface hte_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  symbol;
    logic [15:0] code_word;
    logic [4:0]  code_length;

    modport source (output valid, command, symbol, code_word, code_length, input ready);
    modport sink   (input valid, command, symbol, code_word, code_length, output ready);
endinterface

interface hte_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, out_byte, last_of_run, input ready);
    modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

FILE: sv/hte_packer.sv
// ----------------------------------------------------------------------------
// hte_packer
// bit accumulator: appends a code msb first, splits off whole bytes, flushes
// ----------------------------------------------------------------------------
module hte_packer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  hte_pkg::pack_req_t  req,
    output hte_pkg::pack_res_t  res
);

    logic [hte_pkg::PEND_BITS-1:0] pend_bits_reg, pend_bits_next;
    logic [hte_pkg::CNT_W-1:0]     pend_cnt_reg, pend_cnt_next;

    logic [hte_pkg::WORD_BITS:0]   code_mask_w;
    logic [hte_pkg::WORD_BITS-1:0] code;
    logic [hte_pkg::ACC_W-1:0]     acc;
    logic [hte_pkg::LEN_W-1:0]     total;
    logic [hte_pkg::CNT_W-1:0]     rem;
    logic [3:0]                    flush_shift;

    // append the masked code below the pending bits
    always_comb
    begin
        code_mask_w = ((hte_pkg::WORD_BITS+1)'(1) << req.clen) - (hte_pkg::WORD_BITS+1)'(1);
        code        = req.code & code_mask_w[hte_pkg::WORD_BITS-1:0];
        acc         = (hte_pkg::ACC_W'(pend_bits_reg) << req.clen) | hte_pkg::ACC_W'(code);
        total       = hte_pkg::LEN_W'(pend_cnt_reg) + req.clen;
        rem         = total[hte_pkg::CNT_W-1:0];
        flush_shift = 4'(hte_pkg::BYTE_BITS) - {1'b0, pend_cnt_reg};
    end

    // byte split and next accumulator state
    always_comb
    begin
        res            = '0;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        case (req.cmd)
            hte_pkg::CMD_ENCODE:
            begin
                res.count      = total[4] ? 2'd2 : (total[3] ? 2'd1 : 2'd0);
                res.byte0      = 8'(acc >> (total - 5'(hte_pkg::BYTE_BITS)));
                res.byte1      = 8'(acc >> (total - 5'(2 * hte_pkg::BYTE_BITS)));
                pend_bits_next = acc[hte_pkg::PEND_BITS-1:0]
                               & ~({hte_pkg::PEND_BITS{1'b1}} << rem);
                pend_cnt_next  = rem;
            end
            hte_pkg::CMD_FLUSH:
            begin
                if (pend_cnt_reg != '0)
                begin
                    res.count = 2'd1;
                    res.byte0 = 8'({1'b0, pend_bits_reg} << flush_shift);
                end
                pend_bits_next = '0;
                pend_cnt_next  = '0;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    // accumulator registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end
        else if (fire)
        begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

endmodule

FILE: sv/huffman_table_encoder.sv
// ----------------------------------------------------------------------------
// huffman_table_encoder
// table-driven huffman encoder with a byte-wide bit packer
// ----------------------------------------------------------------------------
// A command beat can be taken in every cycle unless the lookup stage holds a beat
// that cannot move on. The symbol's table entry is read in the cycle the beat is
// accepted, the packer works on it in the next cycle and its bytes are registered
// in the result register before they appear on the byte channel. The output holds
// the bytes of one command, up to two; an encode yielding two bytes holds back a
// following command with bytes until its second byte is being taken, while loads,
// single-byte encodes and flushes run at one per cycle with the output taken.
// The 256-entry code table sits in a memory with one valid flip-flop per entry,
// so unloaded entries give zero-length codes after reset, with no clearing sweep.
// ----------------------------------------------------------------------------
`include "huffman_table_encoder_macros.svh"

module huffman_table_encoder (
    input  logic           clk,
    input  logic           rst_n,
    hte_cmd_if.sink        cmd_ch,
    hte_byte_if.source     byte_ch
);

    logic [hte_pkg::ENTRY_W-1:0] tab_mem [hte_pkg::TABLE_DEPTH];
    logic                        tab_vld_reg [hte_pkg::TABLE_DEPTH];

    logic                        cmd_fire;
    logic                        load_fire;
    logic                        in_range;
    logic [hte_pkg::ADDR_W-1:0]  tab_idx;
    logic [hte_pkg::LEN_W-1:0]   load_len;

    logic                        s1_valid_reg;
    hte_pkg::cmd_t               s1_cmd_reg;
    logic                        s1_hit_reg;
    logic [hte_pkg::ENTRY_W-1:0] s1_entry_reg;
    logic                        s1_adv;

    hte_pkg::pack_req_t          req;
    hte_pkg::pack_res_t          res;

    logic [1:0]                  res_cnt_reg, res_cnt_next;
    logic [7:0]                  res_b0_reg, res_b0_next;
    logic [7:0]                  res_b1_reg, res_b1_next;
    logic                        res_free;
    logic                        byte_fire;

    // command beat decode
    assign tab_idx   = cmd_ch.symbol[hte_pkg::ADDR_W-1:0];
    assign in_range  = {1'b0, cmd_ch.symbol} < 9'(hte_pkg::TABLE_DEPTH);
    assign cmd_fire  = cmd_ch.valid && cmd_ch.ready;
    assign load_fire = cmd_fire && (hte_pkg::cmd_t'(cmd_ch.command) == hte_pkg::CMD_LOAD)
                     && in_range;
    assign load_len  = (cmd_ch.code_length > 5'(hte_pkg::LEN_CAP)) ? 5'(hte_pkg::LEN_CAP)
                                                                    : cmd_ch.code_length;

    // code table write and registered read
    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            tab_mem[tab_idx] <= {load_len, cmd_ch.code_word};
        end
        if (cmd_fire)
        begin
            s1_entry_reg <= tab_mem[tab_idx];
        end
    end

    // per-entry valid flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hte_pkg::TABLE_DEPTH; i++)
            begin
                tab_vld_reg[i] <= 1'b0;
            end
        end
        else if (load_fire)
        begin
            tab_vld_reg[tab_idx] <= 1'b1;
        end
    end

    // lookup stage takes a beat when empty or moving on
    function automatic logic cmd_ready_int();
        return !s1_valid_reg || s1_adv;
    endfunction

    // lookup stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_cmd_reg   <= hte_pkg::CMD_LOAD;
            s1_hit_reg   <= 1'b0;
        end
        else if (cmd_ready_int())
        begin
            s1_valid_reg <= cmd_ch.valid;
            if (cmd_ch.valid)
            begin
                s1_cmd_reg <= hte_pkg::cmd_t'(cmd_ch.command);
                s1_hit_reg <= in_range && tab_vld_reg[tab_idx];
            end
        end
    end

    assign cmd_ch.ready = cmd_ready_int();

    // packer request from the looked-up entry
    always_comb
    begin
        req.cmd  = s1_cmd_reg;
        req.clen = s1_hit_reg ? s1_entry_reg[hte_pkg::ENTRY_W-1:hte_pkg::WORD_BITS] : '0;
        req.code = s1_entry_reg[hte_pkg::WORD_BITS-1:0];
    end

    hte_packer u_packer (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (s1_adv),
        .req   (req),
        .res   (res)
    );

    // advance when the bytes have somewhere to go
    assign byte_fire = byte_ch.valid && byte_ch.ready;
    assign res_free  = (res_cnt_reg == 2'd0) || ((res_cnt_reg == 2'd1) && byte_ch.ready);
    assign s1_adv    = s1_valid_reg && ((res.count == 2'd0) || res_free);

    // result register: bytes of one command, shifted out in order
    always_comb
    begin
        res_cnt_next = res_cnt_reg;
        res_b0_next  = res_b0_reg;
        res_b1_next  = res_b1_reg;
        if (byte_fire)
        begin
            res_cnt_next = res_cnt_reg - 2'd1;
            res_b0_next  = res_b1_reg;
        end
        if (s1_adv && (res.count != 2'd0))
        begin
            res_cnt_next = res.count;
            res_b0_next  = res.byte0;
            res_b1_next  = res.byte1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_cnt_reg <= 2'd0;
        end
        else
        begin
            res_cnt_reg <= res_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_b0_reg <= res_b0_next;
        res_b1_reg <= res_b1_next;
    end

    // byte channel
    assign byte_ch.valid       = (res_cnt_reg != 2'd0);
    assign byte_ch.out_byte    = res_b0_reg;
    assign byte_ch.last_of_run = (res_cnt_reg == 2'd1);

    // checks
    `HTE_ASSERT_NEXT(a_bytes_shown, s1_adv && (res.count != 2'd0), byte_ch.valid)
    `HTE_ASSERT_NEXT(a_pair_shift, (res_cnt_reg == 2'd2) && byte_ch.ready, res_cnt_reg == 2'd1)
    `HTE_ASSERT_NEXT(a_load_marks, load_fire, tab_vld_reg[$past(tab_idx)])
    `HTE_ASSERT_SAME(a_stall_cause, !cmd_ch.ready, s1_valid_reg && (res.count != 2'd0))

endmodule
